// File: hw/rtl/bmf_pkg.sv
// ----------------------------------------------------------------------------
// Blitter minterm and fill package
// Shared constants and types for the minterm and area fill datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package bmf_pkg;

  localparam int unsigned WordBitsDefault = 16;

  localparam int unsigned MintermBits  = 8;
  localparam int unsigned FillModeBits = 2;
  localparam int unsigned ApbDataBits  = 32;
  localparam int unsigned ApbAddrBits  = 4;
  localparam int unsigned RegIdxBits   = 2;

  localparam logic [RegIdxBits-1:0] REG_MINTERM    = 2'd0;
  localparam logic [RegIdxBits-1:0] REG_FILL_MODE  = 2'd1;
  localparam logic [RegIdxBits-1:0] REG_CARRY_INIT = 2'd2;

  localparam int unsigned FillInclBit = 0;
  localparam int unsigned FillExclBit = 1;

  typedef struct packed {
    logic [MintermBits-1:0]  minterm;
    logic [FillModeBits-1:0] fill_mode;
    logic                    fill_carry_init;
  } cfg_t;

endpackage

`default_nettype wire

// File: hw/rtl/bmf_in_if.sv
// ----------------------------------------------------------------------------
// Blitter input channel
// Valid/ready channel carrying the three source words and the row and blit
// start markers.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmf_in_if #(
  parameter int unsigned WORD_BITS = bmf_pkg::WordBitsDefault
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] a_word;
  logic [WORD_BITS-1:0] b_word;
  logic [WORD_BITS-1:0] c_word;
  logic                 row_start;
  logic                 blit_start;

  modport source (output valid, a_word, b_word, c_word, row_start, blit_start,
                  input ready);
  modport sink (input valid, a_word, b_word, c_word, row_start, blit_start,
                output ready);
endinterface

`default_nettype wire

// File: hw/rtl/bmf_out_if.sv
// ----------------------------------------------------------------------------
// Blitter output channel
// Valid/ready channel carrying the destination word, zero flag and carry.
// ----------------------------------------------------------------------------
`default_nettype none

interface bmf_out_if #(
  parameter int unsigned WORD_BITS = bmf_pkg::WordBitsDefault
);
  logic                 valid;
  logic                 ready;
  logic [WORD_BITS-1:0] d_word;
  logic                 all_zero;
  logic                 carry_after;

  modport source (output valid, d_word, all_zero, carry_after, input ready);
  modport sink (input valid, d_word, all_zero, carry_after, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/blitter_minterm_fill_datapath.sv
// ----------------------------------------------------------------------------
// Blitter minterm and area fill datapath
// Combines source words A, B and C through the minterm table, applies
// optional inclusive or exclusive area fill, and tracks the blit zero flag.
//
// Usage:
//   Source words enter on in_i as valid/ready transactions; results leave on
//   out_o in the same order, one result per input transaction. The minterm,
//   fill mode and fill carry init registers sit behind the APB port at byte
//   addresses 0, 4 and 8; the user must write them only while the datapath
//   is idle, as the block does not enforce it. A word passes through one
//   input register, then the word logic into the result register.
//   Throughput is one word per cycle while out_o.ready holds. The fill carry
//   and zero flag are updated as a word moves from the input register into
//   the result register, so consecutive words chain without bubbles.
//   When the receiver stalls, the result register holds and the input
//   register fills; in_i.ready drops only when both are occupied.
//   Reset clears both pipeline stages and the registers, sets the fill carry
//   to zero and the zero flag to one.
// ----------------------------------------------------------------------------
`default_nettype none

module blitter_minterm_fill_datapath #(
  parameter int unsigned WORD_BITS = bmf_pkg::WordBitsDefault
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  bmf_in_if.sink                               in_i,
  bmf_out_if.source                            out_o,
  input  wire logic                            psel,
  input  wire logic                            penable,
  input  wire logic                            pwrite,
  input  wire logic [bmf_pkg::ApbAddrBits-1:0] paddr,
  input  wire logic [bmf_pkg::ApbDataBits-1:0] pwdata,
  output logic      [bmf_pkg::ApbDataBits-1:0] prdata,
  output logic                                 pready
);

  bmf_pkg::cfg_t cfg;

  logic                 s1_valid_q;
  logic [WORD_BITS-1:0] s1_a_q, s1_b_q, s1_c_q;
  logic                 s1_row_q, s1_blit_q;

  logic                 out_valid_q;
  logic [WORD_BITS-1:0] out_d_word_q;
  logic                 out_zero_q, out_carry_q;

  logic                 carry_q, carry_d;
  logic                 zero_q, zero_d;
  logic [WORD_BITS-1:0] d_word_d;

  logic                 out_load;
  logic                 s1_adv;
  logic                 in_take;

  bmf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  bmf_word_logic #(
    .WORD_BITS (WORD_BITS)
  ) u_logic (
    .cfg_i        (cfg),
    .a_word_i     (s1_a_q),
    .b_word_i     (s1_b_q),
    .c_word_i     (s1_c_q),
    .row_start_i  (s1_row_q),
    .blit_start_i (s1_blit_q),
    .carry_i      (carry_q),
    .zero_i       (zero_q),
    .d_word_o     (d_word_d),
    .carry_o      (carry_d),
    .zero_o       (zero_d)
  );

  assign out_load = ~out_valid_q | out_o.ready;
  assign s1_adv   = s1_valid_q & out_load;
  assign in_i.ready = ~s1_valid_q | s1_adv;
  assign in_take  = in_i.valid & in_i.ready;

  assign out_o.valid       = out_valid_q;
  assign out_o.d_word      = out_d_word_q;
  assign out_o.all_zero    = out_zero_q;
  assign out_o.carry_after = out_carry_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      carry_q     <= 1'b0;
      zero_q      <= 1'b1;
    end else begin
      if (in_take) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (out_load) begin
        out_valid_q <= s1_valid_q;
      end
      if (s1_adv) begin
        carry_q <= carry_d;
        zero_q  <= zero_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      s1_a_q    <= in_i.a_word;
      s1_b_q    <= in_i.b_word;
      s1_c_q    <= in_i.c_word;
      s1_row_q  <= in_i.row_start;
      s1_blit_q <= in_i.blit_start;
    end
    if (s1_adv) begin
      out_d_word_q <= d_word_d;
      out_zero_q   <= zero_d;
      out_carry_q  <= carry_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bmf_cfg_regs.sv
// ----------------------------------------------------------------------------
// Blitter configuration registers
// APB register file holding the minterm table, fill mode and carry init.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_cfg_regs (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [bmf_pkg::ApbAddrBits-1:0]   paddr,
  input  wire logic [bmf_pkg::ApbDataBits-1:0]   pwdata,
  output logic      [bmf_pkg::ApbDataBits-1:0]   prdata,
  output logic                                   pready,
  output bmf_pkg::cfg_t                          cfg_o
);

  bmf_pkg::cfg_t                  cfg_q, cfg_d;
  logic [bmf_pkg::RegIdxBits-1:0] idx;
  logic                           wr_en;

  assign idx    = paddr[bmf_pkg::ApbAddrBits-1:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        bmf_pkg::REG_MINTERM: begin
          cfg_d.minterm = pwdata[bmf_pkg::MintermBits-1:0];
        end
        bmf_pkg::REG_FILL_MODE: begin
          cfg_d.fill_mode = pwdata[bmf_pkg::FillModeBits-1:0];
        end
        bmf_pkg::REG_CARRY_INIT: begin
          cfg_d.fill_carry_init = pwdata[0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (idx)
      bmf_pkg::REG_MINTERM: begin
        prdata = {{(bmf_pkg::ApbDataBits-bmf_pkg::MintermBits){1'b0}}, cfg_q.minterm};
      end
      bmf_pkg::REG_FILL_MODE: begin
        prdata = {{(bmf_pkg::ApbDataBits-bmf_pkg::FillModeBits){1'b0}}, cfg_q.fill_mode};
      end
      bmf_pkg::REG_CARRY_INIT: begin
        prdata = {{(bmf_pkg::ApbDataBits-1){1'b0}}, cfg_q.fill_carry_init};
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/bmf_word_logic.sv
// ----------------------------------------------------------------------------
// Blitter word logic
// Minterm combination, area fill with running carry, and zero flag update.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_word_logic #(
  parameter int unsigned WORD_BITS = bmf_pkg::WordBitsDefault
) (
  input  wire bmf_pkg::cfg_t        cfg_i,
  input  wire logic [WORD_BITS-1:0] a_word_i,
  input  wire logic [WORD_BITS-1:0] b_word_i,
  input  wire logic [WORD_BITS-1:0] c_word_i,
  input  wire logic                 row_start_i,
  input  wire logic                 blit_start_i,
  input  wire logic                 carry_i,
  input  wire logic                 zero_i,
  output logic      [WORD_BITS-1:0] d_word_o,
  output logic                      carry_o,
  output logic                      zero_o
);

  logic [WORD_BITS-1:0] mix;
  logic [WORD_BITS-1:0] fill_cy;
  logic [WORD_BITS-1:0] filled;
  logic                 cy_in;
  logic                 fill_en;
  logic                 excl;

  assign cy_in   = row_start_i ? cfg_i.fill_carry_init : carry_i;
  assign excl    = cfg_i.fill_mode[bmf_pkg::FillExclBit];
  assign fill_en = excl | cfg_i.fill_mode[bmf_pkg::FillInclBit];

  always_comb begin
    for (int i = 0; i < int'(WORD_BITS); i++) begin
      mix[i] = cfg_i.minterm[{a_word_i[i], b_word_i[i], c_word_i[i]}];
    end
  end

  // The carry seen by each bit is the incoming carry toggled by every set
  // bit below it, so each bit takes the parity of the lower part of the word.
  always_comb begin
    logic [WORD_BITS-1:0] low_mask;
    low_mask = '0;
    for (int i = 0; i < int'(WORD_BITS); i++) begin
      low_mask   = {WORD_BITS{1'b1}} >> (int'(WORD_BITS) - i);
      fill_cy[i] = cy_in ^ (^(mix & low_mask));
    end
  end

  assign filled = excl ? (mix ^ fill_cy) : (mix | fill_cy);

  assign d_word_o = fill_en ? filled : mix;
  assign carry_o  = fill_en ? (cy_in ^ (^mix)) : cy_in;
  assign zero_o   = (blit_start_i | zero_i) & (d_word_o == '0);

endmodule

`default_nettype wire

// File: hw/rtl/bmf_checker.sv
// ----------------------------------------------------------------------------
// Blitter datapath checker
// Port-level assertions for the minterm and fill datapath, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module bmf_checker #(
  parameter int unsigned WORD_BITS = bmf_pkg::WordBitsDefault
) (
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 out_valid_i,
  input wire logic                 out_ready_i,
  input wire logic [WORD_BITS-1:0] out_d_word_i,
  input wire logic                 out_all_zero_i,
  input wire logic                 out_carry_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=>
      $stable(out_d_word_i) && $stable(out_all_zero_i) && $stable(out_carry_i))
    else $error("result payload changed while stalled");

  a_zero_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_all_zero_i |-> out_d_word_i == '0)
    else $error("zero flag set with a nonzero word");

  a_nonzero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && out_d_word_i != '0 |-> !out_all_zero_i)
    else $error("zero flag kept after a nonzero word");

endmodule

bind blitter_minterm_fill_datapath bmf_checker #(
  .WORD_BITS (WORD_BITS)
) u_bmf_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_d_word_i   (out_o.d_word),
  .out_all_zero_i (out_o.all_zero),
  .out_carry_i    (out_o.carry_after)
);

`default_nettype wire
